// ===== rtl/bca_pkg.sv =====
package bca_pkg;

  // Field widths fixed by the request/result format
  localparam int unsigned CFG_W  = 13;
  localparam int unsigned IDX_W  = 12;
  localparam int unsigned ST_W   = 2;

  // APB register file geometry
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  // Defaults for the top level parameters
  localparam int unsigned NUM_CLUSTERS_DEF  = 4096;
  localparam int unsigned MAP_WORD_BITS_DEF = 8;

  // Register index (paddr[2]) and reset value
  localparam logic             REG_BITMAP_CLUSTERS = 1'b0;
  localparam logic [CFG_W-1:0] CFG_CLUSTERS_RST    = 13'd4096;

  // Clusters 0 and 1 are marked used after a fresh format
  localparam logic [1:0] INIT_USED_MASK = 2'b11;

  // Request codes
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  // Status codes
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd2;

  // Map memory strobes from the sequencer
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } ram_ctrl_t;

endpackage

// ===== rtl/bca_req_if.sv =====
interface bca_req_if;
  logic                       valid;
  logic                       ready;
  logic                       req_type;
  logic [bca_pkg::IDX_W-1:0]  cluster_index;

  modport source (output valid, req_type, cluster_index, input ready);
  modport sink   (input valid, req_type, cluster_index, output ready);
endinterface

// ===== rtl/bca_rsp_if.sv =====
interface bca_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [bca_pkg::IDX_W-1:0]  granted_index;
  logic [bca_pkg::ST_W-1:0]   status;

  modport source (output valid, granted_index, status, input ready);
  modport sink   (input valid, granted_index, status, output ready);
endinterface

// ===== rtl/bitmap_cluster_allocator.sv =====
// First-fit cluster allocator over an on-chip occupancy bitmap.
// req_i (valid/ready) carries one request word: req_type 0 allocates the
// lowest free cluster below the active size, 1 frees cluster_index.
// rsp_o (valid/ready) returns one result word per request: granted_index and
// status (ok, no free cluster, free index out of range).
// The APB port holds the size register at byte address 0; pready is tied high.
// An allocate reads map words up to the first one with a clear bit below the
// active size, or ceil(size / MAP_WORD_BITS) words when full; a free steps
// word by word to the one holding the index. Both walks use the single
// word-step adder, one word per cycle, over the memory's one read port.
// Out-of-range frees skip the map and go straight to the result.
// One request is in flight at a time; req_i.ready is high only when idle, so
// the next request can be taken in the cycle after the result word is loaded.
// Reset runs a clearing pass over all DEPTH map words (512 at defaults),
// clusters 0 and 1 marked used; req_i.ready stays low until it ends.
// A stalled receiver holds the result in the output register; the block still
// takes the next request and parks its result until the register drains.
module bitmap_cluster_allocator #(
  parameter int unsigned NUM_CLUSTERS  = bca_pkg::NUM_CLUSTERS_DEF,
  parameter int unsigned MAP_WORD_BITS = bca_pkg::MAP_WORD_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bca_pkg::PADDR_W-1:0]   paddr,
  input  logic [bca_pkg::PDATA_W-1:0]   pwdata,
  output logic [bca_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  bca_req_if.sink                       req_i,
  bca_rsp_if.source                     rsp_o
);

  localparam int unsigned Depth = (NUM_CLUSTERS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
  localparam int unsigned AW    = (Depth > 1) ? $clog2(Depth) : 1;

  logic [bca_pkg::CFG_W-1:0]   cfg_clusters;
  bca_pkg::ram_ctrl_t          ram_ctrl;
  logic [AW-1:0]               ram_wr_addr;
  logic [MAP_WORD_BITS-1:0]    ram_wr_data;
  logic [AW-1:0]               ram_rd_addr;
  logic [MAP_WORD_BITS-1:0]    ram_rd_data;

  // Configuration register
  bca_apb_regs u_regs (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .cfg_clusters_o (cfg_clusters)
  );

  // Request sequencer with the shared word-step unit
  bca_seq #(
    .NUM_CLUSTERS  (NUM_CLUSTERS),
    .MAP_WORD_BITS (MAP_WORD_BITS),
    .DEPTH         (Depth),
    .AW            (AW)
  ) u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_clusters_i (cfg_clusters),
    .req_valid_i    (req_i.valid),
    .req_ready_o    (req_i.ready),
    .req_type_i     (req_i.req_type),
    .req_index_i    (req_i.cluster_index),
    .rsp_valid_o    (rsp_o.valid),
    .rsp_ready_i    (rsp_o.ready),
    .rsp_granted_o  (rsp_o.granted_index),
    .rsp_status_o   (rsp_o.status),
    .ram_ctrl_o     (ram_ctrl),
    .ram_wr_addr_o  (ram_wr_addr),
    .ram_wr_data_o  (ram_wr_data),
    .ram_rd_addr_o  (ram_rd_addr),
    .ram_rd_data_i  (ram_rd_data)
  );

  // Occupancy bitmap
  bca_map_ram #(
    .DEPTH (Depth),
    .WIDTH (MAP_WORD_BITS),
    .AW    (AW)
  ) u_map (
    .clk_i     (clk_i),
    .ctrl_i    (ram_ctrl),
    .wr_addr_i (ram_wr_addr),
    .wr_data_i (ram_wr_data),
    .rd_addr_i (ram_rd_addr),
    .rd_data_o (ram_rd_data)
  );

endmodule

// ===== rtl/bca_apb_regs.sv =====
module bca_apb_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bca_pkg::PADDR_W-1:0]   paddr,
  input  logic [bca_pkg::PDATA_W-1:0]   pwdata,
  output logic [bca_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  output logic [bca_pkg::CFG_W-1:0]     cfg_clusters_o
);

  logic                        hit_reg;
  logic [bca_pkg::CFG_W-1:0]   clusters_q;

  // Byte offset bits are don't-care, paddr[2] picks the register
  assign hit_reg = (paddr[2] == bca_pkg::REG_BITMAP_CLUSTERS) && (paddr[1:0] == 2'b00
                   || paddr[1:0] != 2'b00);

  // Size register, written on the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clusters_q <= bca_pkg::CFG_CLUSTERS_RST;
    end else if (psel && penable && pwrite && hit_reg) begin
      clusters_q <= pwdata[bca_pkg::CFG_W-1:0];
    end
  end

  // Read back
  always_comb begin
    prdata = '0;
    if (hit_reg) begin
      prdata = bca_pkg::PDATA_W'(clusters_q);
    end
  end

  assign pready         = 1'b1;
  assign cfg_clusters_o = clusters_q;

endmodule

// ===== rtl/bca_map_ram.sv =====
module bca_map_ram #(
  parameter int unsigned DEPTH = 512,
  parameter int unsigned WIDTH = 8,
  parameter int unsigned AW    = 9
) (
  input  logic                 clk_i,
  input  bca_pkg::ram_ctrl_t   ctrl_i,
  input  logic [AW-1:0]        wr_addr_i,
  input  logic [WIDTH-1:0]     wr_data_i,
  input  logic [AW-1:0]        rd_addr_i,
  output logic [WIDTH-1:0]     rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (ctrl_i.rd_en) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/bca_seq.sv =====
module bca_seq #(
  parameter int unsigned NUM_CLUSTERS  = bca_pkg::NUM_CLUSTERS_DEF,
  parameter int unsigned MAP_WORD_BITS = bca_pkg::MAP_WORD_BITS_DEF,
  parameter int unsigned DEPTH         = 512,
  parameter int unsigned AW            = 9
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [bca_pkg::CFG_W-1:0]     cfg_clusters_i,
  // request side
  input  logic                          req_valid_i,
  output logic                          req_ready_o,
  input  logic                          req_type_i,
  input  logic [bca_pkg::IDX_W-1:0]     req_index_i,
  // result side
  output logic                          rsp_valid_o,
  input  logic                          rsp_ready_i,
  output logic [bca_pkg::IDX_W-1:0]     rsp_granted_o,
  output logic [bca_pkg::ST_W-1:0]      rsp_status_o,
  // map memory
  output bca_pkg::ram_ctrl_t            ram_ctrl_o,
  output logic [AW-1:0]                 ram_wr_addr_o,
  output logic [MAP_WORD_BITS-1:0]      ram_wr_data_o,
  output logic [AW-1:0]                 ram_rd_addr_o,
  input  logic [MAP_WORD_BITS-1:0]      ram_rd_data_i
);

  localparam int unsigned BW    = $clog2(MAP_WORD_BITS);
  localparam int unsigned BaseW = bca_pkg::CFG_W + 1;
  localparam int unsigned CapW  = bca_pkg::CFG_W;

  localparam logic [BaseW-1:0]         WordStep = BaseW'(MAP_WORD_BITS);
  localparam logic [AW-1:0]            LastAddr = AW'(DEPTH - 1);
  localparam logic [CapW-1:0]          NumCap   = (NUM_CLUSTERS >= (2 ** CapW)) ?
                                                  {CapW{1'b1}} : CapW'(NUM_CLUSTERS);
  localparam logic [MAP_WORD_BITS-1:0] InitWord = MAP_WORD_BITS'(bca_pkg::INIT_USED_MASK);
  localparam logic [MAP_WORD_BITS-1:0] OneBit   = MAP_WORD_BITS'(1);

  // Sequencer states
  localparam logic [2:0] S_CLEAR    = 3'd0;
  localparam logic [2:0] S_IDLE     = 3'd1;
  localparam logic [2:0] S_SCAN     = 3'd2;
  localparam logic [2:0] S_ALLOC_WR = 3'd3;
  localparam logic [2:0] S_WALK     = 3'd4;
  localparam logic [2:0] S_FREE_WR  = 3'd5;
  localparam logic [2:0] S_DONE     = 3'd6;

  logic [2:0]                  state_q, state_d;
  logic [AW-1:0]               addr_q, addr_d;
  logic [BaseW-1:0]            base_q, base_d;
  logic [BW-1:0]               bit_q, bit_d;
  logic [bca_pkg::IDX_W-1:0]   idx_q, idx_d;
  logic [MAP_WORD_BITS-1:0]    word_q, word_d;
  logic [MAP_WORD_BITS-1:0]    free_q, free_d;
  logic [bca_pkg::IDX_W-1:0]   res_granted_q, res_granted_d;
  logic [bca_pkg::ST_W-1:0]    res_status_q, res_status_d;
  logic                        rsp_valid_q, rsp_valid_d;
  logic [bca_pkg::IDX_W-1:0]   rsp_granted_q, rsp_granted_d;
  logic [bca_pkg::ST_W-1:0]    rsp_status_q, rsp_status_d;

  logic [CapW-1:0]             limit;
  logic [BaseW-1:0]            limit_ext;
  logic [BaseW-1:0]            step_sum;
  logic [BaseW-1:0]            rem;
  logic [MAP_WORD_BITS-1:0]    mask;
  logic [MAP_WORD_BITS-1:0]    free_bits;
  logic [BaseW-1:0]            idx_ext;
  logic                        walk_hit;
  logic [BaseW-1:0]            walk_off;
  logic [BW-1:0]               ff_idx;
  logic [BaseW-1:0]            grant_sum;

  // Active size, saturated to the map size
  assign limit     = (cfg_clusters_i > NumCap) ? NumCap : cfg_clusters_i;
  assign limit_ext = BaseW'(limit);

  // Shared word-step adder, used by both the allocate scan and the free walk
  assign step_sum = base_q + WordStep;

  // Clusters of the current word that lie below the active size
  assign rem = limit_ext - base_q;
  always_comb begin
    for (int j = 0; j < MAP_WORD_BITS; j++) begin
      mask[j] = (BaseW'(j) < rem);
    end
  end
  assign free_bits = ~ram_rd_data_i & mask;

  // Free walk: does the target index fall into the current word
  assign idx_ext  = BaseW'(idx_q);
  assign walk_hit = idx_ext < step_sum;
  assign walk_off = idx_ext - base_q;

  // Lowest clear bit of the latched word
  always_comb begin
    ff_idx = '0;
    for (int j = MAP_WORD_BITS - 1; j >= 0; j--) begin
      if (free_q[j]) begin
        ff_idx = BW'(j);
      end
    end
  end
  assign grant_sum = base_q + BaseW'(ff_idx);

  // Next state and datapath
  always_comb begin
    state_d       = state_q;
    addr_d        = addr_q;
    base_d        = base_q;
    bit_d         = bit_q;
    idx_d         = idx_q;
    word_d        = word_q;
    free_d        = free_q;
    res_granted_d = res_granted_q;
    res_status_d  = res_status_q;
    rsp_granted_d = rsp_granted_q;
    rsp_status_d  = rsp_status_q;
    rsp_valid_d   = rsp_valid_q && !rsp_ready_i;
    ram_ctrl_o    = '0;
    ram_wr_addr_o = addr_q;
    ram_wr_data_o = '0;
    ram_rd_addr_o = addr_q;

    case (state_q)
      // Clearing pass after reset, one word per cycle
      S_CLEAR: begin
        ram_ctrl_o.wr_en = 1'b1;
        ram_wr_data_o    = (addr_q == '0) ? InitWord : '0;
        if (addr_q == LastAddr) begin
          addr_d  = '0;
          state_d = S_IDLE;
        end else begin
          addr_d = addr_q + 1'b1;
        end
      end

      S_IDLE: begin
        if (req_valid_i) begin
          addr_d = '0;
          base_d = '0;
          idx_d  = req_index_i;
          if (req_type_i == bca_pkg::REQ_ALLOC) begin
            ram_ctrl_o.rd_en = 1'b1;
            ram_rd_addr_o    = '0;
            state_d          = S_SCAN;
          end else if (BaseW'(req_index_i) >= limit_ext) begin
            res_granted_d = '0;
            res_status_d  = bca_pkg::ST_RANGE;
            state_d       = S_DONE;
          end else begin
            state_d = S_WALK;
          end
        end
      end

      // One map word per cycle, next read issued in parallel
      S_SCAN: begin
        if (base_q >= limit_ext) begin
          res_granted_d = '0;
          res_status_d  = bca_pkg::ST_FULL;
          state_d       = S_DONE;
        end else if (free_bits != '0) begin
          word_d  = ram_rd_data_i;
          free_d  = free_bits;
          state_d = S_ALLOC_WR;
        end else begin
          base_d           = step_sum;
          addr_d           = addr_q + 1'b1;
          ram_ctrl_o.rd_en = 1'b1;
          ram_rd_addr_o    = addr_q + 1'b1;
        end
      end

      // Mark the found cluster used
      S_ALLOC_WR: begin
        ram_ctrl_o.wr_en = 1'b1;
        ram_wr_data_o    = word_q | (OneBit << ff_idx);
        res_granted_d    = grant_sum[bca_pkg::IDX_W-1:0];
        res_status_d     = bca_pkg::ST_OK;
        state_d          = S_DONE;
      end

      // Step word by word to the one holding the index
      S_WALK: begin
        if (walk_hit) begin
          bit_d            = walk_off[BW-1:0];
          ram_ctrl_o.rd_en = 1'b1;
          state_d          = S_FREE_WR;
        end else begin
          base_d = step_sum;
          addr_d = addr_q + 1'b1;
        end
      end

      S_FREE_WR: begin
        ram_ctrl_o.wr_en = 1'b1;
        ram_wr_data_o    = ram_rd_data_i & ~(OneBit << bit_q);
        res_granted_d    = '0;
        res_status_d     = bca_pkg::ST_OK;
        state_d          = S_DONE;
      end

      // Hand the word to the output register once it is free
      S_DONE: begin
        if (!rsp_valid_q || rsp_ready_i) begin
          rsp_valid_d   = 1'b1;
          rsp_granted_d = res_granted_q;
          rsp_status_d  = res_status_q;
          state_d       = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      addr_q      <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      addr_q      <= addr_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    base_q        <= base_d;
    bit_q         <= bit_d;
    idx_q         <= idx_d;
    word_q        <= word_d;
    free_q        <= free_d;
    res_granted_q <= res_granted_d;
    res_status_q  <= res_status_d;
    rsp_granted_q <= rsp_granted_d;
    rsp_status_q  <= rsp_status_d;
  end

  assign req_ready_o   = (state_q == S_IDLE);
  assign rsp_valid_o   = rsp_valid_q;
  assign rsp_granted_o = rsp_granted_q;
  assign rsp_status_o  = rsp_status_q;

endmodule

// ===== rtl/bca_checker.sv =====
module bca_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          req_valid_i,
  input logic                          req_ready_i,
  input logic                          rsp_valid_i,
  input logic                          rsp_ready_i,
  input logic [bca_pkg::IDX_W-1:0]     rsp_granted_i,
  input logic [bca_pkg::ST_W-1:0]      rsp_status_i
);

  // A stalled result word holds
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_granted_i)
                                    && $stable(rsp_status_i))
    else $error("result word changed while stalled");

  // Taking a request makes the block busy
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken while a request was in flight");

  // A failed request never names a cluster
  a_fail_no_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_status_i != bca_pkg::ST_OK |-> rsp_granted_i == '0)
    else $error("non-ok result carries a cluster index");

  // Map clearing keeps the request side closed right after reset
  a_clear_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !req_ready_i && !rsp_valid_i)
    else $error("block open before the map was cleared");

endmodule

bind bitmap_cluster_allocator bca_checker u_bca_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .req_valid_i   (req_i.valid),
  .req_ready_i   (req_i.ready),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .rsp_granted_i (rsp_o.granted_index),
  .rsp_status_i  (rsp_o.status)
);

// ===== bench/cluster_alloc_checker.sv =====
`timescale 1ns / 1ps

// Watches the request, result and APB channels of the allocator, keeps its own
// copy of the occupancy bitmap and size register, and checks every result word
// against the oldest outstanding prediction.
module cluster_alloc_checker #(
  parameter int unsigned NUM_CLUSTERS = bca_pkg::NUM_CLUSTERS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic                        pready,
  input  logic [bca_pkg::PADDR_W-1:0] paddr,
  input  logic [bca_pkg::PDATA_W-1:0] pwdata,
  bca_req_if                          req_mon,
  bca_rsp_if                          rsp_mon,
  output int                          fail_cnt,
  output int                          outstanding,
  output int                          words_checked,
  output int                          full_seen,
  output int                          range_seen
);
  import bca_pkg::*;

  typedef struct packed {
    logic [IDX_W-1:0] granted;
    logic [ST_W-1:0]  status;
  } alloc_result_t;

  // Predicted result words, oldest first
  alloc_result_t           due_results[$];
  logic [NUM_CLUSTERS-1:0] used_map = NUM_CLUSTERS'(INIT_USED_MASK);
  logic [CFG_W-1:0]        size_reg = CFG_CLUSTERS_RST;
  int                      errs     = 0;
  int                      n_words  = 0;
  int                      n_full   = 0;
  int                      n_range  = 0;

  // First-fit allocate or free against the local bitmap copy
  function automatic alloc_result_t serve_request(input logic             rt,
                                                  input logic [IDX_W-1:0] idx);
    int unsigned   lim;
    alloc_result_t r;
    bit            hit;
    lim      = (size_reg > NUM_CLUSTERS) ? NUM_CLUSTERS : size_reg;
    r.granted = '0;
    r.status  = ST_OK;
    hit       = 1'b0;
    if (rt == REQ_ALLOC) begin
      for (int unsigned c = 0; c < lim && !hit; c++) begin
        if (!used_map[c]) begin
          used_map[c] = 1'b1;
          r.granted   = IDX_W'(c);
          hit         = 1'b1;
        end
      end
      if (!hit) r.status = ST_FULL;
    end else if (idx >= lim) begin
      // out of range: map untouched
      r.status = ST_RANGE;
    end else begin
      used_map[idx] = 1'b0;
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    alloc_result_t want;
    if (!rst_ni) begin
      used_map       = '0;
      used_map[1:0]  = INIT_USED_MASK;
      size_reg       = CFG_CLUSTERS_RST;
      due_results.delete();
    end else begin
      // size register snoop; writes to other slots are dropped
      if (psel && penable && pwrite && pready &&
          paddr[PADDR_W-1:2] == REG_BITMAP_CLUSTERS) begin
        size_reg = pwdata[CFG_W-1:0];
      end

      if (req_mon.valid && req_mon.ready) begin
        want = serve_request(req_mon.req_type, req_mon.cluster_index);
        if (want.status == ST_FULL)  n_full++;
        if (want.status == ST_RANGE) n_range++;
        due_results.push_back(want);
      end

      if (rsp_mon.valid && rsp_mon.ready) begin
        if (due_results.size() == 0) begin
          errs++;
          $display("%0t: unexpected result word: granted_index %0d status %0d",
                   $time, rsp_mon.granted_index, rsp_mon.status);
        end else begin
          want = due_results.pop_front();
          n_words++;
          if (rsp_mon.granted_index !== want.granted) begin
            errs++;
            $display("%0t: granted_index expected %0d, actual %0d",
                     $time, want.granted, rsp_mon.granted_index);
          end
          if (rsp_mon.status !== want.status) begin
            errs++;
            $display("%0t: status expected %0d, actual %0d",
                     $time, want.status, rsp_mon.status);
          end
        end
      end
    end
    fail_cnt      <= errs;
    outstanding   <= due_results.size();
    words_checked <= n_words;
    full_seen     <= n_full;
    range_seen    <= n_range;
  end

endmodule

// ===== bench/tb_bitmap_cluster_allocator.sv =====
`timescale 1ns / 1ps

module tb_bitmap_cluster_allocator;
  import bca_pkg::*;

  // second register slot, not implemented by the block
  localparam logic        REG_SPARE    = 1'b1;
  localparam int unsigned HOLD_CYCLES  = 600;
  localparam int unsigned DRAIN_CYCLES = 600;
  localparam int          PHASE_ITEMS  = 133;
  localparam int          NUM_PHASES   = 10;

  typedef enum int {RX_STEADY, RX_BUSY, RX_SPARSE} rx_mode_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  int fail_cnt;
  int outstanding;
  int words_checked;
  int full_seen;
  int range_seen;

  int       hold_req   = 0;
  int       hold_ack   = 0;
  int       hold_left  = 0;
  rx_mode_t rx_mode    = RX_STEADY;
  int       mode_left  = 0;
  int       burst_left = 0;
  int       items_sent = 0;
  int       sizes_used = 0;

  bca_req_if req_ch ();
  bca_rsp_if rsp_ch ();

  bitmap_cluster_allocator i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .req_i   (req_ch),
    .rsp_o   (rsp_ch)
  );

  cluster_alloc_checker #(
    .NUM_CLUSTERS (NUM_CLUSTERS_DEF)
  ) i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .pready        (pready),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .req_mon       (req_ch),
    .rsp_mon       (rsp_ch),
    .fail_cnt      (fail_cnt),
    .outstanding   (outstanding),
    .words_checked (words_checked),
    .full_seen     (full_seen),
    .range_seen    (range_seen)
  );

  always #4 clk_i = ~clk_i;

  // Result side: long hold on request, otherwise a changing stall pattern
  always @(posedge clk_i) begin
    if (hold_ack != hold_req) begin
      hold_ack  = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      rsp_ch.ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode   = rx_mode_t'($urandom_range(0, 2));
        mode_left = $urandom_range(16, 96);
      end
      mode_left--;
      case (rx_mode)
        RX_STEADY: rsp_ch.ready <= 1'b1;
        RX_BUSY:   rsp_ch.ready <= ($urandom_range(0, 3) != 0);
        default:   rsp_ch.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Offer one request word, in bursts with random gaps, and wait for it to go
  task automatic send_word(input logic rt, input logic [IDX_W-1:0] idx);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 10);
      if (gap != 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 12);
    end
    req_ch.valid         <= 1'b1;
    req_ch.req_type      <= rt;
    req_ch.cluster_index <= idx;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    burst_left--;
    items_sent++;
  endtask

  // APB write: setup then access, done when pready is seen
  task automatic write_reg(input logic reg_sel, input logic [PDATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (reg_sel == REG_BITMAP_CLUSTERS) sizes_used++;
  endtask

  // Stop offering and wait until every predicted word has come back;
  // it steps past the current edge first so the count includes a word taken there
  task automatic settle();
    req_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Random mix under one size setting; frees mostly hit the low, busy region
  task automatic random_phase(input logic [CFG_W-1:0] size, input int n, input bit hold);
    int unsigned      lim;
    int unsigned      pick;
    logic             rt;
    logic [IDX_W-1:0] idx;
    settle();
    write_reg(REG_BITMAP_CLUSTERS, PDATA_W'(size));
    if (hold) hold_req <= hold_req + 1;
    lim = (size > NUM_CLUSTERS_DEF) ? NUM_CLUSTERS_DEF : size;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      idx  = IDX_W'($urandom());
      rt   = (pick < 55) ? REQ_ALLOC : REQ_FREE;
      if (rt == REQ_FREE && lim != 0) begin
        if (pick < 80) begin
          idx = IDX_W'($urandom_range(0, ((lim < 64) ? lim : 64) - 1));
        end else if (pick < 90) begin
          idx = IDX_W'($urandom_range(0, lim - 1));
        end else if (pick < 95) begin
          // right at the size boundary
          idx = (lim >= NUM_CLUSTERS_DEF) ? IDX_W'(lim - 1) : IDX_W'(lim);
        end
      end
      send_word(rt, idx);
    end
  endtask

  initial begin
    logic [CFG_W-1:0] phase_size[NUM_PHASES];
    rst_ni               = 1'b0;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    req_ch.valid         = 1'b0;
    req_ch.req_type      = REQ_ALLOC;
    req_ch.cluster_index = '0;
    rsp_ch.ready         = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Fresh map at full size: reserved clusters, reuse of freed ones
    send_word(REQ_ALLOC, '1);
    send_word(REQ_ALLOC, '0);
    send_word(REQ_FREE, IDX_W'(0));
    send_word(REQ_ALLOC, '0);
    send_word(REQ_FREE, IDX_W'(1));
    send_word(REQ_FREE, IDX_W'(1));
    send_word(REQ_ALLOC, '1);
    send_word(REQ_FREE, '1);
    send_word(REQ_FREE, IDX_W'(3));
    send_word(REQ_ALLOC, '0);
    settle();

    // Size 8: fill up, run into full, frees past the end
    write_reg(REG_BITMAP_CLUSTERS, 8);
    repeat (6) send_word(REQ_ALLOC, '0);
    send_word(REQ_FREE, IDX_W'(8));
    send_word(REQ_FREE, '1);
    send_word(REQ_FREE, IDX_W'(7));
    send_word(REQ_ALLOC, '0);
    settle();

    // Write to the unused slot has no effect
    write_reg(REG_SPARE, 0);
    send_word(REQ_ALLOC, '0);
    settle();

    // Zero size: nothing to allocate, nothing in range
    write_reg(REG_BITMAP_CLUSTERS, 0);
    send_word(REQ_ALLOC, '0);
    send_word(REQ_FREE, IDX_W'(0));
    settle();

    // Size field at its maximum saturates to the whole map
    write_reg(REG_BITMAP_CLUSTERS, PDATA_W'({CFG_W{1'b1}}));
    send_word(REQ_FREE, '1);
    send_word(REQ_ALLOC, '0);

    // Random part, mostly small sizes
    phase_size = '{13'd16, 13'd8, 13'd40, 13'd4096, 13'd9, 13'd200, 13'd24,
                   13'd8191, 13'd12, 13'd100};
    phase_size[8] = CFG_W'($urandom_range(8, 64));
    phase_size[9] = CFG_W'($urandom_range(8, 4096));
    for (int p = 0; p < NUM_PHASES; p++) begin
      random_phase(phase_size[p], PHASE_ITEMS, (p == 1 || p == 6));
    end
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("%0d request words over %0d size settings, %0d result words checked",
             items_sent, sizes_used, words_checked);
    $display("%0d no-free-cluster and %0d out-of-range results, two long receiver holds",
             full_seen, range_seen);
    if (fail_cnt == 0 && outstanding == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #30ms;
    $display("simulation failed");
    $finish;
  end

endmodule
